>>> sv/swrl_pkg.sv
// Shared types, codes and defaults of the sliding-window rate limiter.
package swrl_pkg;

   localparam int DEF_NUM_SLOTS = 256;
   localparam int DEF_LOG_DEPTH = 16;
   localparam int DEF_TIME_BITS = 32;

   localparam int NUM_SCOPES = 4;
   localparam int LIMIT_W    = 5;
   localparam int WINDOW_W   = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] CMD_CONSUME = 3'd0;
   localparam logic [2:0] CMD_RESERVE = 3'd1;
   localparam logic [2:0] CMD_COMMIT  = 3'd2;
   localparam logic [2:0] CMD_CANCEL  = 3'd3;
   localparam logic [2:0] CMD_RESET   = 3'd4;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_DENIED    = 2'd1;
   localparam logic [1:0] ST_NO_RESERV = 2'd2;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET [NUM_SCOPES] = '{5'd5, 5'd5, 5'd10, 5'd10};
   localparam logic [WINDOW_W-1:0] WINDOW_RESET [NUM_SCOPES] =
      '{32'd3600, 32'd60, 32'd60, 32'd60};

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  scope;
      logic [7:0]  ip_slot;
      logic        has_user;
      logic [7:0]  user_slot;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic       granted;
      logic [1:0] status;
   } rsp_type;

endpackage

>>> sv/swrl_age_cmp.sv
// Wraparound age of a logged timestamp compared with the scope window.
module swrl_age_cmp import swrl_pkg::*; #(
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic [TIME_BITS-1:0] now,
   input  logic [TIME_BITS-1:0] stamp,
   input  logic [WINDOW_W-1:0]  window,
   output logic                 expired
);
   localparam int CW = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

   logic [TIME_BITS-1:0] age;

   assign age     = now - stamp;
   assign expired = CW'(age) >= CW'(window);
endmodule

>>> sv/swrl_store.sv
// Slot table and timestamp log memories, each with one write and one registered read port.
module swrl_store import swrl_pkg::*; #(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int LOG_DEPTH = DEF_LOG_DEPTH,
   parameter int TIME_BITS = DEF_TIME_BITS,
   parameter int SE_W      = 8
) (
   input  logic                                  clock,
   input  logic [$clog2(NUM_SLOTS)-1:0]          sl_rd_addr,
   output logic [SE_W-1:0]                       sl_rd_data,
   input  logic                                  sl_we,
   input  logic [$clog2(NUM_SLOTS)-1:0]          sl_wr_addr,
   input  logic [SE_W-1:0]                       sl_wr_data,
   input  logic [$clog2(NUM_SLOTS*LOG_DEPTH)-1:0] lg_rd_addr,
   output logic [TIME_BITS-1:0]                  lg_rd_data,
   input  logic                                  lg_we,
   input  logic [$clog2(NUM_SLOTS*LOG_DEPTH)-1:0] lg_wr_addr,
   input  logic [TIME_BITS-1:0]                  lg_wr_data
);
   logic [SE_W-1:0]      slot_mem [NUM_SLOTS];
   logic [TIME_BITS-1:0] log_mem [NUM_SLOTS*LOG_DEPTH];

   always_ff @(posedge clock) begin
      if (sl_we) begin
         slot_mem[sl_wr_addr] <= sl_wr_data;
      end
      sl_rd_data <= slot_mem[sl_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lg_we) begin
         log_mem[lg_wr_addr] <= lg_wr_data;
      end
      lg_rd_data <= log_mem[lg_rd_addr];
   end
endmodule

>>> sv/sliding_window_rate_limiter_core.sv
// Top level of the sliding-window rate limiter: sequencer, registers and result stage.
// After reset the slot table is cleared one slot per cycle, and no request is taken meanwhile
// (configuration writes are). A request then reads and checks each named slot in turn; a consume
// or reserve also walks the slot's log, with a read and an age compare for every timestamp it
// examines and one more read when the slot's log is or becomes empty. After that come a step to
// decide, one step per slot to update it, one to hand over the result and one in idle to take the
// next request. A refused request skips the update, and an unknown command goes straight to the
// hand-over. The walk is paced by the single read port of the log memory, which it reads one
// timestamp at a time through one age comparator. The result sits in an output register, so the
// next request may be accepted while it waits.
module sliding_window_rate_limiter_core import swrl_pkg::*; #(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int LOG_DEPTH = DEF_LOG_DEPTH,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LA_W   = $clog2(NUM_SLOTS * LOG_DEPTH);
   localparam int HEAD_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
   localparam int SE_W   = HEAD_W + 2 * CNT_W;
   localparam int SUM_W  = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_RDSLOT    = 4'd2;
   localparam logic [3:0] S_SLOT      = 4'd3;
   localparam logic [3:0] S_PRUNE_RD  = 4'd4;
   localparam logic [3:0] S_PRUNE_CMP = 4'd5;
   localparam logic [3:0] S_CHECK     = 4'd6;
   localparam logic [3:0] S_DECIDE    = 4'd7;
   localparam logic [3:0] S_APPLY     = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;

   logic [LIMIT_W-1:0]  lim_ff [NUM_SCOPES];
   logic [WINDOW_W-1:0] win_ff [NUM_SCOPES];

   req_type req_ff, req_in;
   logic [SLOT_W-1:0] slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic two_ff, two_in;
   logic idx_ff, idx_in;

   logic [HEAD_W-1:0] cur_head_ff, cur_head_in;
   logic [CNT_W-1:0]  cur_cnt_ff, cur_cnt_in, cur_pend_ff, cur_pend_in;
   logic [HEAD_W-1:0] sv_head_ff [2];
   logic [CNT_W-1:0]  sv_cnt_ff [2];
   logic [CNT_W-1:0]  sv_pend_ff [2];
   logic              sv_we;

   logic       granted_ff, granted_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic [SLOT_W-1:0] mod_tab [256];

   logic [SLOT_W-1:0]    sl_rd_addr, sl_wr_addr, cur_slot;
   logic [SE_W-1:0]      sl_rd_data, sl_wr_data;
   logic                 sl_we;
   logic [LA_W-1:0]      lg_rd_addr, lg_wr_addr;
   logic [TIME_BITS-1:0] lg_rd_data, now_t;
   logic                 lg_we;
   logic                 expired;

   logic [HEAD_W-1:0] ap_head, nh;
   logic [CNT_W-1:0]  ap_cnt, ap_pend, nc, np;
   logic [HEAD_W-1:0] pos;
   logic [CNT_W:0]    pos_sum;
   logic [SUM_W-1:0]  use_sum;
   logic              is_cr, accept;

   always_comb begin
      for (int i = 0; i < 256; i++) begin
         mod_tab[i] = SLOT_W'(i % NUM_SLOTS);
      end
   end

   assign now_t    = TIME_BITS'(req_ff.now);
   assign cur_slot = idx_ff ? slot1_ff : slot0_ff;
   assign is_cr    = (req_ff.command == CMD_CONSUME) || (req_ff.command == CMD_RESERVE);
   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign use_sum   = SUM_W'(cur_cnt_ff) + SUM_W'(cur_pend_ff);

   swrl_age_cmp #(.TIME_BITS(TIME_BITS)) u_age (
      .now     (now_t),
      .stamp   (lg_rd_data),
      .window  (win_ff[req_ff.scope]),
      .expired (expired)
   );

   swrl_store #(
      .NUM_SLOTS (NUM_SLOTS),
      .LOG_DEPTH (LOG_DEPTH),
      .TIME_BITS (TIME_BITS),
      .SE_W      (SE_W)
   ) u_store (
      .clock      (clock),
      .sl_rd_addr (sl_rd_addr),
      .sl_rd_data (sl_rd_data),
      .sl_we      (sl_we),
      .sl_wr_addr (sl_wr_addr),
      .sl_wr_data (sl_wr_data),
      .lg_rd_addr (lg_rd_addr),
      .lg_rd_data (lg_rd_data),
      .lg_we      (lg_we),
      .lg_wr_addr (lg_wr_addr),
      .lg_wr_data (now_t)
   );

   // New slot entry for the update step of the slot selected by idx_ff.
   always_comb begin
      ap_head = sv_head_ff[idx_ff];
      ap_cnt  = sv_cnt_ff[idx_ff];
      ap_pend = sv_pend_ff[idx_ff];
      nh = ap_head;
      nc = ap_cnt;
      np = ap_pend;
      pos_sum = (CNT_W + 1)'(ap_head) + (CNT_W + 1)'(ap_cnt);
      if (pos_sum >= (CNT_W + 1)'(LOG_DEPTH)) begin
         pos_sum = pos_sum - (CNT_W + 1)'(LOG_DEPTH);
      end
      pos = HEAD_W'(pos_sum);
      if (ap_cnt < CNT_W'(LOG_DEPTH)) begin
         if (req_ff.command == CMD_CONSUME || req_ff.command == CMD_COMMIT) begin
            nc = ap_cnt + CNT_W'(1);
         end
      end else begin
         pos = ap_head;
         if (req_ff.command == CMD_CONSUME || req_ff.command == CMD_COMMIT) begin
            nh = (ap_head == HEAD_W'(LOG_DEPTH - 1)) ? '0 : ap_head + HEAD_W'(1);
         end
      end
      case (req_ff.command)
         CMD_RESERVE: begin
            if (ap_pend < CNT_W'(LOG_DEPTH)) begin
               np = ap_pend + CNT_W'(1);
            end
         end
         CMD_COMMIT: np = ap_pend - CNT_W'(1);
         CMD_CANCEL: begin
            if (ap_pend != '0) begin
               np = ap_pend - CNT_W'(1);
            end
         end
         CMD_RESET: begin
            nh = '0;
            nc = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      slot0_in     = slot0_ff;
      slot1_in     = slot1_ff;
      two_in       = two_ff;
      idx_in       = idx_ff;
      cur_head_in  = cur_head_ff;
      cur_cnt_in   = cur_cnt_ff;
      cur_pend_in  = cur_pend_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      sv_we        = 1'b0;
      sl_rd_addr   = cur_slot;
      sl_we        = 1'b0;
      sl_wr_addr   = cur_slot;
      sl_wr_data   = {cur_head_ff, cur_cnt_ff, cur_pend_ff};
      lg_rd_addr   = LA_W'(cur_slot) * LA_W'(LOG_DEPTH) + LA_W'(cur_head_ff);
      lg_we        = 1'b0;
      lg_wr_addr   = LA_W'(cur_slot) * LA_W'(LOG_DEPTH) + LA_W'(pos);

      case (state_ff)
         S_CLEAR: begin
            sl_we      = 1'b1;
            sl_wr_addr = clr_ff;
            sl_wr_data = '0;
            clr_in     = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               slot0_in   = mod_tab[req_data.ip_slot];
               slot1_in   = mod_tab[req_data.user_slot];
               two_in     = req_data.has_user &&
                            (mod_tab[req_data.user_slot] != mod_tab[req_data.ip_slot]);
               idx_in     = 1'b0;
               granted_in = 1'b0;
               status_in  = ST_DONE;
               if (req_data.command > CMD_RESET) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_RDSLOT;
               end
            end
         end
         S_RDSLOT: state_in = S_SLOT;
         S_SLOT: begin
            {cur_head_in, cur_cnt_in, cur_pend_in} = sl_rd_data;
            state_in = is_cr ? S_PRUNE_RD : S_CHECK;
         end
         S_PRUNE_RD: begin
            state_in = (cur_cnt_ff == '0) ? S_CHECK : S_PRUNE_CMP;
         end
         S_PRUNE_CMP: begin
            if (expired) begin
               cur_head_in = (cur_head_ff == HEAD_W'(LOG_DEPTH - 1)) ? '0
                                                                      : cur_head_ff + HEAD_W'(1);
               cur_cnt_in  = cur_cnt_ff - CNT_W'(1);
               state_in    = S_PRUNE_RD;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            sv_we = 1'b1;
            sl_we = is_cr;
            if (is_cr && use_sum >= SUM_W'(lim_ff[req_ff.scope])) begin
               status_in = ST_DENIED;
               state_in  = S_FINISH;
            end else if (!idx_ff && two_ff) begin
               idx_in   = 1'b1;
               state_in = S_RDSLOT;
            end else begin
               idx_in   = 1'b0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (req_ff.command == CMD_COMMIT &&
                (sv_pend_ff[0] == '0 || (two_ff && sv_pend_ff[1] == '0))) begin
               status_in = ST_NO_RESERV;
               state_in  = S_FINISH;
            end else begin
               granted_in = is_cr;
               state_in   = S_APPLY;
            end
         end
         S_APPLY: begin
            sl_we      = 1'b1;
            sl_wr_data = {nh, nc, np};
            lg_we      = (req_ff.command == CMD_CONSUME) || (req_ff.command == CMD_COMMIT);
            if (!idx_ff && two_ff) begin
               idx_in = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.granted = granted_ff;
               rsp_data_in.status  = status_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SCOPES; i++) begin
            lim_ff[i] <= LIMIT_RESET[i];
            win_ff[i] <= WINDOW_RESET[i];
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_addr[0]) begin
               win_ff[csr_addr[2:1]] <= csr_wdata[WINDOW_W-1:0];
            end else begin
               lim_ff[csr_addr[2:1]] <= csr_wdata[LIMIT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      slot0_ff    <= slot0_in;
      slot1_ff    <= slot1_in;
      two_ff      <= two_in;
      idx_ff      <= idx_in;
      cur_head_ff <= cur_head_in;
      cur_cnt_ff  <= cur_cnt_in;
      cur_pend_ff <= cur_pend_in;
      granted_ff  <= granted_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (sv_we) begin
         sv_head_ff[idx_ff] <= cur_head_ff;
         sv_cnt_ff[idx_ff]  <= cur_cnt_ff;
         sv_pend_ff[idx_ff] <= cur_pend_ff;
      end
   end
endmodule

>>> dv/swrl_checker.sv
// Checker of the rate limiter: predicts each result from accepted requests and compares.
module swrl_checker import swrl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    outstanding
);

   localparam int SLOTS = DEF_NUM_SLOTS;
   localparam int DEPTH = DEF_LOG_DEPTH;
   localparam int VERDICT_SLOTS = 16;

   logic [31:0]         stamp_mem [SLOTS*DEPTH];
   int                  ring_head [SLOTS];
   int                  stamp_count [SLOTS];
   int                  held_count [SLOTS];
   logic [LIMIT_W-1:0]  scope_limit [NUM_SCOPES];
   logic [WINDOW_W-1:0] scope_window [NUM_SCOPES];
   rsp_type             verdict_ring [VERDICT_SLOTS];
   int                  verdict_rd = 0;
   int                  verdict_wr = 0;

   initial error_count = 0;
   assign outstanding = verdict_wr - verdict_rd;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("checker: %s mismatch, got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic void drop_expired(input int s, input logic [31:0] now,
                                        input logic [31:0] window);
      logic [31:0] age;
      while (stamp_count[s] > 0) begin
         age = now - stamp_mem[s*DEPTH + ring_head[s]];
         if (age < window) break;
         ring_head[s] = (ring_head[s] + 1) % DEPTH;
         stamp_count[s]--;
      end
   endfunction

   function automatic void log_stamp(input int s, input logic [31:0] now);
      if (stamp_count[s] < DEPTH) begin
         stamp_mem[s*DEPTH + (ring_head[s] + stamp_count[s]) % DEPTH] = now;
         stamp_count[s]++;
      end else begin
         stamp_mem[s*DEPTH + ring_head[s]] = now;
         ring_head[s] = (ring_head[s] + 1) % DEPTH;
      end
   endfunction

   function automatic rsp_type admit_request(input req_type r);
      int      sl [2];
      int      n;
      bit      ok;
      rsp_type res;
      res = '0;
      sl[0] = r.ip_slot;
      sl[1] = r.user_slot;
      n = (r.has_user && r.user_slot != r.ip_slot) ? 2 : 1;
      ok = 1;
      case (r.command)
         CMD_CONSUME, CMD_RESERVE: begin
            // The user slot is left untouched once the address slot is refused.
            for (int i = 0; i < n && ok; i++) begin
               drop_expired(sl[i], r.now, scope_window[r.scope]);
               if (stamp_count[sl[i]] + held_count[sl[i]] >= scope_limit[r.scope]) ok = 0;
            end
            if (ok) begin
               for (int i = 0; i < n; i++) begin
                  if (r.command == CMD_CONSUME) log_stamp(sl[i], r.now);
                  else if (held_count[sl[i]] < DEPTH) held_count[sl[i]]++;
               end
               res.granted = 1'b1;
               res.status = ST_DONE;
            end else begin
               res.status = ST_DENIED;
            end
         end
         CMD_COMMIT: begin
            for (int i = 0; i < n; i++) if (held_count[sl[i]] == 0) ok = 0;
            if (ok) begin
               for (int i = 0; i < n; i++) begin
                  log_stamp(sl[i], r.now);
                  held_count[sl[i]]--;
               end
               res.status = ST_DONE;
            end else begin
               res.status = ST_NO_RESERV;
            end
         end
         CMD_CANCEL: begin
            for (int i = 0; i < n; i++) if (held_count[sl[i]] > 0) held_count[sl[i]]--;
         end
         CMD_RESET: begin
            for (int i = 0; i < n; i++) begin
               stamp_count[sl[i]] = 0;
               ring_head[sl[i]] = 0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            ring_head[s] = 0;
            stamp_count[s] = 0;
            held_count[s] = 0;
         end
         for (int k = 0; k < NUM_SCOPES; k++) begin
            scope_limit[k] = LIMIT_RESET[k];
            scope_window[k] = WINDOW_RESET[k];
         end
         verdict_rd = 0;
         verdict_wr = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_wr == verdict_rd) begin
               $display("checker: result beat with nothing expected at %0t", $time);
               error_count++;
            end else begin
               want = verdict_ring[verdict_rd % VERDICT_SLOTS];
               verdict_rd++;
               if (rsp_data.granted !== want.granted)
                  report_mismatch("granted", rsp_data.granted, want.granted);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
         end
         if (req_valid && !req_stall) begin
            if (verdict_wr - verdict_rd >= VERDICT_SLOTS) begin
               $display("checker: too many results outstanding at %0t", $time);
               error_count++;
            end else begin
               verdict_ring[verdict_wr % VERDICT_SLOTS] = admit_request(req_data);
               verdict_wr++;
            end
         end
         if (csr_we) begin
            if (csr_addr[0] == 1'b0) scope_limit[csr_addr >> 1] = csr_wdata[LIMIT_W-1:0];
            else scope_window[csr_addr >> 1] = csr_wdata;
         end
      end
   end

endmodule

>>> dv/testbench.sv
// Top of the rate limiter testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
   import swrl_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [CSR_ADDR_W-1:0] REG_REGISTRATION_LIMIT  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_REGISTRATION_WINDOW = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LOGIN_LIMIT         = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LOGIN_WINDOW        = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_UPLOAD_LIMIT        = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_UPLOAD_WINDOW       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_POST_LIMIT          = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_POST_WINDOW         = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    error_count;
   int                    outstanding;
   int                    cycles = 0;
   bit                    idle_on = 1'b1;
   bit                    hold_request = 1'b0;
   logic [31:0]           clock_now = 32'd0;

   sliding_window_rate_limiter_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   swrl_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .error_count(error_count), .outstanding(outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Result side: random stall bursts, and one long hold-off on request.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Leaves the write enable high; the caller drops it after its last write.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_scopes(input logic [31:0] l0, w0, l1, w1, l2, w2, l3, w3);
      write_reg(REG_REGISTRATION_LIMIT, l0);
      write_reg(REG_REGISTRATION_WINDOW, w0);
      write_reg(REG_LOGIN_LIMIT, l1);
      write_reg(REG_LOGIN_WINDOW, w1);
      write_reg(REG_UPLOAD_LIMIT, l2);
      write_reg(REG_UPLOAD_WINDOW, w2);
      write_reg(REG_POST_LIMIT, l3);
      write_reg(REG_POST_WINDOW, w3);
      csr_we <= 1'b0;
   endtask

   task automatic send_beat(input req_type r);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(input logic [2:0] cmd, input logic [1:0] scope,
                              input logic [7:0] ip, input logic has_user,
                              input logic [7:0] user, input logic [31:0] now);
      req_type r;
      r.command = cmd;
      r.scope = scope;
      r.ip_slot = ip;
      r.has_user = has_user;
      r.user_slot = user;
      r.now = now;
      send_beat(r);
   endtask

   // Waits until every expected result is back, so the block is idle.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_slot();
      return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] pick_command();
      int w;
      w = $urandom_range(0, 99);
      if (w < 40) return CMD_CONSUME;
      if (w < 60) return CMD_RESERVE;
      if (w < 75) return CMD_COMMIT;
      if (w < 87) return CMD_CANCEL;
      if (w < 95) return CMD_RESET;
      return 3'($urandom_range(5, 7));
   endfunction

   task automatic random_traffic(input int count, input int step, input bit with_hold);
      req_type r;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 2) hold_request = 1'b1;
         // Mostly a slowly advancing clock; now and then a jump anywhere.
         if ($urandom_range(0, 19) == 0) clock_now = $urandom;
         else clock_now = clock_now + $urandom_range(0, step);
         r.command = pick_command();
         r.scope = 2'($urandom_range(0, 3));
         r.ip_slot = pick_slot();
         r.has_user = 1'($urandom_range(0, 1));
         r.user_slot = ($urandom_range(0, 9) == 0) ? r.ip_slot : pick_slot();
         r.now = clock_now;
         send_beat(r);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings.
      send_fields(CMD_CONSUME, 2'd0, 8'd0, 1'b1, 8'd255, 32'd0);
      send_fields(CMD_CONSUME, 2'd3, 8'd255, 1'b1, 8'd0, 32'hFFFF_FFFF);
      send_fields(CMD_CONSUME, 2'd1, 8'd9, 1'b1, 8'd9, 32'd10);
      for (int i = 0; i < 6; i++) send_fields(CMD_CONSUME, 2'd1, 8'd1, 1'b0, 8'd0, 32'd20);
      send_fields(CMD_CONSUME, 2'd1, 8'd1, 1'b0, 8'd0, 32'd80);
      send_fields(CMD_COMMIT, 2'd2, 8'd2, 1'b1, 8'd3, 32'd100);
      send_fields(CMD_RESERVE, 2'd2, 8'd2, 1'b1, 8'd3, 32'd101);
      send_fields(CMD_COMMIT, 2'd2, 8'd2, 1'b1, 8'd3, 32'd102);
      send_fields(CMD_RESERVE, 2'd3, 8'd4, 1'b0, 8'd0, 32'd103);
      send_fields(CMD_CANCEL, 2'd3, 8'd4, 1'b1, 8'd5, 32'd104);
      send_fields(CMD_CANCEL, 2'd3, 8'd4, 1'b0, 8'd0, 32'd105);
      send_fields(CMD_RESET, 2'd0, 8'd1, 1'b1, 8'd2, 32'd106);
      send_fields(3'd5, 2'd1, 8'd1, 1'b0, 8'd0, 32'd107);
      send_fields(3'd7, 2'd2, 8'd1, 1'b0, 8'd0, 32'd108);
      send_fields(CMD_CONSUME, 2'd1, 8'd1, 1'b0, 8'd0, 32'd109);
      drain();

      random_traffic(300, 4, 1'b0);
      drain();

      write_scopes(32'd1, 32'd1, 32'd2, 32'd5, 32'd3, 32'd20, 32'd16, 32'd100);
      random_traffic(400, 6, 1'b1);
      drain();

      // Limits of zero and the widest setting, windows of zero and the largest.
      write_scopes(32'd0, 32'd0, 32'd31, 32'hFFFF_FFFF, 32'd16, 32'd0, 32'd31, 32'd1);
      for (int i = 0; i < 20; i++) send_fields(CMD_CONSUME, 2'd1, 8'd7, 1'b0, 8'd0, 32'(i));
      random_traffic(300, 3, 1'b0);
      drain();

      write_scopes($urandom_range(1, 16), $urandom_range(1, 40), $urandom_range(1, 16),
                   $urandom_range(1, 40), $urandom_range(1, 16), $urandom_range(1, 40),
                   $urandom_range(1, 16), $urandom_range(1, 40));
      random_traffic(350, 5, 1'b0);
      idle_on = 1'b0;
      random_traffic(250, 5, 1'b0);
      drain();

      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

>>> sliding_window_rate_limiter_core.f
sv/swrl_pkg.sv
sv/swrl_age_cmp.sv
sv/swrl_store.sv
sv/sliding_window_rate_limiter_core.sv
dv/swrl_checker.sv
dv/testbench.sv
